FILE: rtl/alternating_bit_sender_assert.svh
// assertion macros shared by the alternating-bit sender modules
// expects clk and rst_n in the scope where a macro is used
`ifndef ALTERNATING_BIT_SENDER_ASSERT_SVH
`define ALTERNATING_BIT_SENDER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ABS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ABS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/abs_pkg.sv
// shared types and constants of the alternating-bit sender
// no dependencies
`default_nettype none

package abs_pkg;

  // packet geometry
  localparam int PAYLOAD_BYTES = 20;
  localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

  // field widths
  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int SUM_W  = 13;
  localparam int TMR_W  = 16;

  // timeout register reset value
  localparam logic [TMR_W-1:0] TIMEOUT_RESET = 16'd20;

  // input command codes
  localparam logic [CMD_W-1:0] CMD_MSG     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

  // one input transaction
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] data_byte;
    logic              ack_number;
    logic [SUM_W-1:0]  ack_checksum;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    logic [BYTE_W-1:0] packet_byte;
    logic              packet_last;
    logic              packet_sequence;
    logic [SUM_W-1:0]  packet_sum;
    logic              timer_start;
    logic [TMR_W-1:0]  timer_load;
    logic              timer_stop;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;   // input transaction taken this cycle
    logic prime;    // start buffer read of the first byte
    logic send;     // queue one resent byte
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic q_space;      // output queue can take one more result
    logic timeout_hit;  // current input is a timeout while waiting
    logic resend_last;  // resend counter is at the final byte
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/abs_in_if.sv
// input channel of the alternating-bit sender: valid/ready plus payload
// depends on abs_pkg
`default_nettype none

interface abs_in_if import abs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] data_byte;
  logic              ack_number;
  logic [SUM_W-1:0]  ack_checksum;

  modport source (output valid, command, data_byte, ack_number, ack_checksum,
                  input ready);
  modport sink (input valid, command, data_byte, ack_number, ack_checksum,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/abs_out_if.sv
// result channel of the alternating-bit sender: valid/ready plus payload
// depends on abs_pkg
`default_nettype none

interface abs_out_if import abs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] packet_byte;
  logic              packet_last;
  logic              packet_sequence;
  logic [SUM_W-1:0]  packet_sum;
  logic              timer_start;
  logic [TMR_W-1:0]  timer_load;
  logic              timer_stop;

  modport source (output valid, packet_byte, packet_last, packet_sequence,
                  packet_sum, timer_start, timer_load, timer_stop,
                  input ready);
  modport sink (input valid, packet_byte, packet_last, packet_sequence,
                packet_sum, timer_start, timer_load, timer_stop,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/abs_ctrl.sv
// controller of the alternating-bit sender: input handshake and resend sequencing
// depends on abs_pkg and alternating_bit_sender_assert.svh
`default_nettype none

`include "alternating_bit_sender_assert.svh"

module abs_ctrl import abs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PRIME  = 2'd1;
  localparam logic [1:0] S_RESEND = 2'd2;

  logic [1:0] state_r, state_nxt;

  // next state and commands
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = status.q_space;
        cmd.accept = in_valid && status.q_space;
        if (cmd.accept && status.timeout_hit) begin
          state_nxt = S_PRIME;
        end
      end
      S_PRIME: begin
        cmd.prime = 1'b1;
        state_nxt = S_RESEND;
      end
      S_RESEND: begin
        if (status.q_space) begin
          cmd.send = 1'b1;
          if (status.resend_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // checks
  `ABS_ASSERT_NEXT(a_timeout_blocks_input, cmd.accept && status.timeout_hit,
                   !in_ready && cmd.prime, "timeout did not start a resend")
  `ABS_ASSERT_NEXT(a_resend_ends_idle, cmd.send && status.resend_last,
                   state_r == S_IDLE, "resend did not return to idle")
  `ABS_ASSERT_NOW(a_one_command, 1'b1, $onehot0({cmd.accept, cmd.prime, cmd.send}),
                  "controller issued overlapping commands")

endmodule

`default_nettype wire

FILE: rtl/abs_dp.sv
// datapath of the alternating-bit sender: counters, sums, retransmit buffer,
// output queue; depends on abs_pkg and alternating_bit_sender_assert.svh
`default_nettype none

`include "alternating_bit_sender_assert.svh"

module abs_dp import abs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire in_item_t         in_item,
  input  wire ctrl_cmd_t        cmd,
  input  wire logic [TMR_W-1:0] timeout,
  output dp_status_t            status,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_item
);

  // protocol state
  logic             ready_r, ready_nxt;
  logic             seq_r, seq_nxt;
  logic             drop_r, drop_nxt;
  logic [IDX_W-1:0] msg_cnt_r, msg_cnt_nxt;
  logic [IDX_W-1:0] ack_cnt_r, ack_cnt_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [SUM_W-1:0] msg_sum_r, msg_sum_nxt;
  logic [SUM_W-1:0] ack_sum_r, ack_sum_nxt;
  logic [SUM_W-1:0] stored_sum_r, stored_sum_nxt;

  // retransmit buffer
  logic [BYTE_W-1:0] buf_mem [PAYLOAD_BYTES];
  logic [BYTE_W-1:0] rd_data_r;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;

  // output queue, two entries
  out_item_t q_r [2];
  logic      wp_r, rp_r;
  logic [1:0] count_r, count_nxt;
  logic      push, pop;
  out_item_t push_item;

  logic             is_msg, is_ack, msg_first, msg_last, msg_drop, msg_wr;
  logic             ack_first, ack_last, ack_ok;
  logic [SUM_W-1:0] byte_ext, msg_sum_new, ack_sum_new;

  // decode of the accepted transaction
  always_comb begin
    byte_ext    = {{(SUM_W - BYTE_W){1'b0}}, in_item.data_byte};
    is_msg      = cmd.accept && (in_item.command == CMD_MSG);
    is_ack      = cmd.accept && (in_item.command == CMD_ACK);
    msg_first   = (msg_cnt_r == '0);
    msg_last    = (msg_cnt_r == LAST_IDX);
    msg_drop    = msg_first ? !ready_r : drop_r;
    msg_wr      = is_msg && !msg_drop;
    msg_sum_new = (msg_first ? '0 : msg_sum_r) + byte_ext;
    ack_first   = (ack_cnt_r == '0);
    ack_last    = (ack_cnt_r == LAST_IDX);
    ack_sum_new = (ack_first ? '0 : ack_sum_r) + byte_ext;
    ack_ok      = is_ack && ack_last && !ready_r && (in_item.ack_checksum == ack_sum_new)
                  && (in_item.ack_number == seq_r);
  end

  // next protocol state
  always_comb begin
    ready_nxt      = ready_r;
    seq_nxt        = seq_r;
    drop_nxt       = drop_r;
    msg_cnt_nxt    = msg_cnt_r;
    ack_cnt_nxt    = ack_cnt_r;
    msg_sum_nxt    = msg_sum_r;
    ack_sum_nxt    = ack_sum_r;
    stored_sum_nxt = stored_sum_r;
    k_nxt          = k_r;
    if (is_msg) begin
      msg_sum_nxt = msg_sum_new;
      msg_cnt_nxt = msg_last ? '0 : msg_cnt_r + 1'b1;
      drop_nxt    = msg_last ? 1'b0 : msg_drop;
      if (msg_wr && msg_last) begin
        stored_sum_nxt = msg_sum_new;
        ready_nxt      = 1'b0;
      end
    end
    if (is_ack) begin
      ack_sum_nxt = ack_sum_new;
      ack_cnt_nxt = ack_last ? '0 : ack_cnt_r + 1'b1;
    end
    if (ack_ok) begin
      seq_nxt   = !seq_r;
      ready_nxt = 1'b1;
    end
    if (cmd.prime) begin
      k_nxt = '0;
    end else if (cmd.send) begin
      k_nxt = status.resend_last ? '0 : k_r + 1'b1;
    end
  end

  // result selection
  always_comb begin
    push_item = '0;
    push      = 1'b0;
    if (msg_wr) begin
      push                      = 1'b1;
      push_item.packet_byte     = in_item.data_byte;
      push_item.packet_last     = msg_last;
      push_item.packet_sequence = seq_r;
      push_item.packet_sum      = msg_last ? msg_sum_new : '0;
      push_item.timer_start     = msg_last;
      push_item.timer_load      = msg_last ? timeout : '0;
    end else if (ack_ok) begin
      push                 = 1'b1;
      push_item.timer_stop = 1'b1;
    end else if (cmd.send) begin
      push                      = 1'b1;
      push_item.packet_byte     = rd_data_r;
      push_item.packet_last     = status.resend_last;
      push_item.packet_sequence = seq_r;
      push_item.packet_sum      = status.resend_last ? stored_sum_r : '0;
      push_item.timer_start     = status.resend_last;
      push_item.timer_load      = status.resend_last ? timeout : '0;
    end
  end

  // status toward the controller
  always_comb begin
    status.q_space     = (count_r != 2'd2);
    status.timeout_hit = (in_item.command == CMD_TIMEOUT) && !ready_r;
    status.resend_last = (k_r == LAST_IDX);
  end

  // buffer read: first byte on prime, the following byte on each send
  always_comb begin
    rd_en   = cmd.prime || (cmd.send && !status.resend_last);
    rd_addr = cmd.prime ? '0 : k_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (msg_wr) begin
      buf_mem[msg_cnt_r] <= in_item.data_byte;
    end
    if (rd_en) begin
      rd_data_r <= buf_mem[rd_addr];
    end
  end

  // output queue
  always_comb begin
    out_valid = (count_r != 2'd0);
    out_item  = q_r[rp_r];
    pop       = out_valid && out_ready;
    count_nxt = 2'(count_r + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_item;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r      <= 1'b1;
      seq_r        <= 1'b0;
      drop_r       <= 1'b0;
      msg_cnt_r    <= '0;
      ack_cnt_r    <= '0;
      k_r          <= '0;
      msg_sum_r    <= '0;
      ack_sum_r    <= '0;
      stored_sum_r <= '0;
      wp_r         <= 1'b0;
      rp_r         <= 1'b0;
      count_r      <= 2'd0;
    end else begin
      ready_r      <= ready_nxt;
      seq_r        <= seq_nxt;
      drop_r       <= drop_nxt;
      msg_cnt_r    <= msg_cnt_nxt;
      ack_cnt_r    <= ack_cnt_nxt;
      k_r          <= k_nxt;
      msg_sum_r    <= msg_sum_nxt;
      ack_sum_r    <= ack_sum_nxt;
      stored_sum_r <= stored_sum_nxt;
      wp_r         <= wp_r ^ push;
      rp_r         <= rp_r ^ pop;
      count_r      <= count_nxt;
    end
  end

  // checks
  `ABS_ASSERT_NOW(a_push_has_room, push, count_r != 2'd2, "result pushed into full queue")
  `ABS_ASSERT_NOW(a_resend_while_waiting, cmd.send || cmd.prime, !ready_r,
                  "resend while ready for a message")
  `ABS_ASSERT_NEXT(a_ack_flips_seq, ack_ok, seq_r != $past(seq_r) && ready_r,
                   "accepted ack did not flip the sequence bit")

endmodule

`default_nettype wire

FILE: rtl/alternating_bit_sender.sv
// top level of the alternating-bit sender: joins controller and datapath
// depends on abs_pkg, abs_in_if, abs_out_if, abs_ctrl, abs_dp
`default_nettype none

// Stop-and-wait sender. Each byte of a message (command 0) that begins while
// the sender is ready leaves as one packet byte on out_ch; the last byte of
// a packet carries the checksum and a timer start with the cfg_wdata
// timeout. A good final ack byte (command 1) gives a single timer_stop
// result. A timeout (command 2) while waiting resends the buffered packet:
// the input is held while the first byte is fetched from the retransmit
// buffer and then while one byte per cycle goes out, stalling whenever the
// output queue is full. Results pass through a two-entry output queue, so
// input is taken while one result waits; with both entries full the input
// stalls until out_ch drains. cfg_we writes the timeout register (reset 20)
// and is meant for idle times.
module alternating_bit_sender import abs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  abs_in_if.sink                in_ch,
  abs_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic [TMR_W-1:0] cfg_wdata
);

  logic [TMR_W-1:0] timeout_r;
  ctrl_cmd_t        cmd;
  dp_status_t       status;
  in_item_t         in_item;
  out_item_t        out_item;
  logic             out_valid;
  logic             in_ready;

  // timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  // channel payload packing
  always_comb begin
    in_item.command      = in_ch.command;
    in_item.data_byte    = in_ch.data_byte;
    in_item.ack_number   = in_ch.ack_number;
    in_item.ack_checksum = in_ch.ack_checksum;
  end

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid;
  assign out_ch.packet_byte     = out_item.packet_byte;
  assign out_ch.packet_last     = out_item.packet_last;
  assign out_ch.packet_sequence = out_item.packet_sequence;
  assign out_ch.packet_sum      = out_item.packet_sum;
  assign out_ch.timer_start     = out_item.timer_start;
  assign out_ch.timer_load      = out_item.timer_load;
  assign out_ch.timer_stop      = out_item.timer_stop;

  abs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  abs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .timeout   (timeout_r),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// self-checking bench for the alternating-bit sender: random stalls on both channels
// predicts every packet byte, resend and timer stop from its own model of the sender
// depends on abs_pkg, abs_in_if, abs_out_if and alternating_bit_sender
`default_nettype none

module tb_top import abs_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SUM_MAX = (1 << SUM_W) - 1;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 25;

  typedef in_item_t item_q_t[$];

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [TMR_W-1:0] cfg_wdata;

  abs_in_if in_ch ();
  abs_out_if out_ch ();

  alternating_bit_sender dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // link items waiting to be offered, and packet results still owed by the block
  item_q_t link_q;
  out_item_t awaited_q[$];
  int items_offered = 0;
  int mismatches = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  // idle bookkeeping of both sides
  int in_gap = 0;
  int in_calm = 0;
  int out_wait = 0;
  int out_calm = 0;
  int hold_left = 0;

  string field_names[7] = '{"packet_byte", "packet_last", "packet_sequence", "packet_sum",
                            "timer_start", "timer_load", "timer_stop"};

  // sender state as the predictor sees it
  logic              sender_ready = 1'b1;
  logic              seq_bit = 1'b0;
  logic [BYTE_W-1:0] resend_buf [PAYLOAD_BYTES];
  int                msg_count = 0;
  logic [SUM_W-1:0]  msg_sum = '0;
  logic [SUM_W-1:0]  held_sum = '0;
  logic              drop_msg = 1'b0;
  int                ack_count = 0;
  logic [SUM_W-1:0]  ack_sum = '0;
  logic [TMR_W-1:0]  timeout_val = TIMEOUT_RESET;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // expected packet results of one accepted transaction
  function automatic void predict_packets(in_item_t it);
    out_item_t r;
    logic      last_byte;
    int        k;
    r = '0;
    case (it.command)
      CMD_MSG: begin
        last_byte = (msg_count == PAYLOAD_BYTES - 1);
        // the first byte decides whether the whole message is dropped
        if (msg_count == 0) begin
          drop_msg = !sender_ready;
          msg_sum = '0;
        end
        if (!drop_msg) begin
          msg_sum = msg_sum + it.data_byte;
          resend_buf[msg_count] = it.data_byte;
          r.packet_byte = it.data_byte;
          r.packet_sequence = seq_bit;
          if (last_byte) begin
            held_sum = msg_sum;
            r.packet_last = 1'b1;
            r.packet_sum = held_sum;
            r.timer_start = 1'b1;
            r.timer_load = timeout_val;
            sender_ready = 1'b0;
          end
          awaited_q.push_back(r);
        end
        msg_count = last_byte ? 0 : msg_count + 1;
        if (last_byte) drop_msg = 1'b0;
      end
      CMD_ACK: begin
        if (ack_count == 0) ack_sum = '0;
        ack_sum = ack_sum + it.data_byte;
        if (ack_count < PAYLOAD_BYTES - 1) begin
          ack_count++;
        end else begin
          ack_count = 0;
          // only a clean ack for the current bit while waiting counts
          if (!sender_ready && it.ack_checksum == ack_sum && it.ack_number == seq_bit) begin
            r.timer_stop = 1'b1;
            awaited_q.push_back(r);
            seq_bit = ~seq_bit;
            sender_ready = 1'b1;
          end
        end
      end
      CMD_TIMEOUT: begin
        // resend of the buffered packet while waiting
        if (!sender_ready) begin
          for (k = 0; k < PAYLOAD_BYTES; k++) begin
            r = '0;
            r.packet_byte = resend_buf[k];
            r.packet_sequence = seq_bit;
            if (k == PAYLOAD_BYTES - 1) begin
              r.packet_last = 1'b1;
              r.packet_sum = held_sum;
              r.timer_start = 1'b1;
              r.timer_load = timeout_val;
            end
            awaited_q.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // wait before the next transaction, with occasional runs of no wait at all
  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  // one transaction of the given command with random fields
  function automatic in_item_t one_item(logic [CMD_W-1:0] cmd);
    in_item_t it;
    it.command = cmd;
    it.data_byte = BYTE_W'($urandom);
    it.ack_number = 1'($urandom);
    it.ack_checksum = SUM_W'($urandom);
    return it;
  endfunction

  // a full message or ack of payload bytes; fill < 0 means random bytes,
  // sum_err flips bits of the checksum carried on the last byte
  function automatic item_q_t make_block(logic [CMD_W-1:0] cmd, int fill, logic ackno,
                                         int sum_err);
    item_q_t q;
    in_item_t it;
    logic [SUM_W-1:0] s;
    s = '0;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      it = one_item(cmd);
      if (fill >= 0) it.data_byte = BYTE_W'(fill);
      s = s + it.data_byte;
      q.push_back(it);
    end
    q[PAYLOAD_BYTES - 1].ack_number = ackno;
    q[PAYLOAD_BYTES - 1].ack_checksum = s ^ SUM_W'(sum_err);
    return q;
  endfunction

  // random merge of two streams, each keeping its own order
  function automatic item_q_t interleave(item_q_t a, item_q_t b);
    item_q_t q;
    while (a.size() != 0 || b.size() != 0) begin
      if (b.size() == 0 || (a.size() != 0 && $urandom_range(0, 1) == 0))
        q.push_back(a.pop_front());
      else
        q.push_back(b.pop_front());
    end
    return q;
  endfunction

  task automatic offer(item_q_t q);
    foreach (q[i]) link_q.push_back(q[i]);
    items_offered += q.size();
  endtask

  // all queued transactions taken by the block
  task automatic drain_link();
    while (link_q.size() != 0 || in_ch.valid) @(negedge clk);
  endtask

  // block idle: nothing queued, nothing owed, and time for ignored work to end
  task automatic settle();
    drain_link();
    while (awaited_q.size() != 0) @(negedge clk);
    repeat (PAYLOAD_BYTES + 5) @(negedge clk);
  endtask

  // one exchange built from the exact sender state, or a burst of noise
  task automatic run_episode();
    item_q_t blk;
    logic    s;
    int      fill;
    drain_link();
    s = seq_bit;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 4))
          0: link_q.push_back(one_item(CMD_UNUSED));
          1: link_q.push_back(one_item(CMD_TIMEOUT));
          2: offer(make_block(CMD_MSG, -1, 1'b0, 0));
          3: offer(make_block(CMD_ACK, -1, 1'($urandom), 0));
          default: offer(make_block(CMD_ACK, -1, 1'($urandom), $urandom_range(1, SUM_MAX)));
        endcase
      end
    end else begin
      case ($urandom_range(0, 7))
        0: fill = 0;
        1: fill = 255;
        default: fill = -1;
      endcase
      // new packet, sometimes with a corrupt ack woven through it
      if (sender_ready) begin
        if ($urandom_range(0, 2) == 0)
          offer(interleave(make_block(CMD_MSG, fill, 1'b0, 0),
                           make_block(CMD_ACK, -1, 1'($urandom), $urandom_range(1, SUM_MAX))));
        else
          offer(make_block(CMD_MSG, fill, 1'b0, 0));
      end
      // timer expiries while waiting
      repeat (($urandom_range(0, 3) == 0) ? 2 : $urandom_range(0, 1))
        link_q.push_back(one_item(CMD_TIMEOUT));
      // a refused ack
      case ($urandom_range(0, 3))
        0: offer(make_block(CMD_ACK, -1, ~s, 0));
        1: offer(make_block(CMD_ACK, -1, s, $urandom_range(1, SUM_MAX)));
        default: ;
      endcase
      // the good ack, sometimes landing inside a message that is being dropped
      if ($urandom_range(0, 2) == 0) begin
        blk = make_block(CMD_MSG, -1, 1'b0, 0);
        link_q.push_back(blk.pop_front());
        offer(interleave(blk, make_block(CMD_ACK, fill, s, 0)));
      end else begin
        offer(make_block(CMD_ACK, fill, s, 0));
      end
    end
  endtask

  // input driver
  always @(posedge clk) begin : link_driver
    in_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_gap > 0 || link_q.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end else begin
        nxt = link_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.command <= nxt.command;
        in_ch.data_byte <= nxt.data_byte;
        in_ch.ack_number <= nxt.ack_number;
        in_ch.ack_checksum <= nxt.ack_checksum;
        in_gap <= pick_wait(in_calm);
      end
    end
  end

  // monitor: predict on input transactions, check output transactions, drive ready
  always @(posedge clk) begin : result_monitor
    in_item_t    seen;
    out_item_t   got;
    out_item_t   want;
    logic [31:0] want_f [7];
    logic [31:0] got_f [7];
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_wait = 0;
      hold_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        seen.command = in_ch.command;
        seen.data_byte = in_ch.data_byte;
        seen.ack_number = in_ch.ack_number;
        seen.ack_checksum = in_ch.ack_checksum;
        predict_packets(seen);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.packet_byte = out_ch.packet_byte;
        got.packet_last = out_ch.packet_last;
        got.packet_sequence = out_ch.packet_sequence;
        got.packet_sum = out_ch.packet_sum;
        got.timer_start = out_ch.timer_start;
        got.timer_load = out_ch.timer_load;
        got.timer_stop = out_ch.timer_stop;
        got_f = '{got.packet_byte, got.packet_last, got.packet_sequence, got.packet_sum,
                  got.timer_start, got.timer_load, got.timer_stop};
        if (awaited_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual byte %0d last %0b stop %0b",
                   $time, got.packet_byte, got.packet_last, got.timer_stop);
          mismatches++;
        end else begin
          want = awaited_q.pop_front();
          want_f = '{want.packet_byte, want.packet_last, want.packet_sequence,
                     want.packet_sum, want.timer_start, want.timer_load, want.timer_stop};
          for (int i = 0; i < 7; i++) begin
            if (want_f[i] !== got_f[i]) begin
              $display("%0t: %s expected %0d actual %0d", $time, field_names[i],
                       want_f[i], got_f[i]);
              mismatches++;
            end
          end
        end
        results_seen++;
        out_wait = pick_wait(out_calm);
        // long hold-offs so the output queue fills and the input stalls
        if (results_seen == 60 || results_seen == 400) hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL alternating_bit_sender");
        $finish;
      end
    end
  end

  // reset, directed sequences, then random exchanges under several timeouts
  initial begin : stimulus
    item_q_t     blk;
    int unsigned phase_timeouts [4];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = TIMEOUT_RESET;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_MSG;
    in_ch.data_byte = '0;
    in_ch.ack_number = 1'b0;
    in_ch.ack_checksum = '0;
    out_ch.ready = 1'b0;
    phase_timeouts = '{(1 << TMR_W) - 1, 1, $urandom_range(2, (1 << TMR_W) - 2),
                       TIMEOUT_RESET};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // all-ones packet and a resend of it
    offer(make_block(CMD_MSG, 255, 1'b0, 0));
    link_q.push_back(one_item(CMD_TIMEOUT));
    // refused acks: wrong number, checksum off by one
    offer(make_block(CMD_ACK, 255, 1'b1, 0));
    offer(make_block(CMD_ACK, 255, 1'b0, 1));
    // message begun while waiting stays dropped though the ack lands mid-way
    blk = make_block(CMD_MSG, -1, 1'b0, 0);
    link_q.push_back(blk.pop_front());
    offer(interleave(blk, make_block(CMD_ACK, 255, 1'b0, 0)));
    // ready again: stray timeout, unused command, ack while ready
    link_q.push_back(one_item(CMD_TIMEOUT));
    link_q.push_back(one_item(CMD_UNUSED));
    offer(make_block(CMD_ACK, -1, 1'b1, 0));
    // all-zero packet with sequence 1 and its ack
    offer(make_block(CMD_MSG, 0, 1'b0, 0));
    offer(make_block(CMD_ACK, 0, 1'b1, 0));

    // random phases, timeout register rewritten while idle
    for (int p = 0; p < 4; p++) begin
      settle();
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_wdata <= TMR_W'(phase_timeouts[p]);
      timeout_val = TMR_W'(phase_timeouts[p]);
      @(posedge clk);
      cfg_we <= 1'b0;
      @(negedge clk);
      items_offered = 0;
      while (items_offered < PHASE_ITEMS) run_episode();
    end

    settle();
    if (mismatches == 0)
      $display("PASS alternating_bit_sender");
    else
      $display("FAIL alternating_bit_sender");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/abs_pkg.sv
rtl/abs_in_if.sv
rtl/abs_out_if.sv
rtl/abs_ctrl.sv
rtl/abs_dp.sv
rtl/alternating_bit_sender.sv
test/tb_top.sv
